// ===== sv/rcam_pkg.sv =====
// Shared types and constants for the rounded-corner alpha mask.
// Used by the register block, the geometry front end,
// the square-root cells and the top level.
`default_nettype none

package rcam_pkg;

    // Classification of one pixel against the corner circle.
    typedef enum logic [1:0] {
        CLS_KEEP  = 2'd0,
        CLS_SCALE = 2'd1,
        CLS_CLEAR = 2'd2
    } t_cls;

    // Pixel word as it travels down the pipeline.
    typedef struct packed {
        t_cls        cls;
        logic [31:0] pixel;
    } t_word;

    // Configuration register indexes (byte address is 4 times the index).
    localparam int          APB_ADDR_W        = 4;
    localparam int          APB_DATA_W        = 32;
    localparam logic [1:0]  REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0]  REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0]  REG_ARC_RADIUS    = 2'd2;

    // Reset values of the configuration registers.
    localparam int          FRAME_SIZE_RESET  = 256;
    localparam int          RADIUS_RESET      = 0;

    // Pixel layout and coverage format.
    localparam int          ALPHA_LSB         = 24;
    localparam logic [31:0] PIXEL_CLEARED     = 32'h0000_0000;
    localparam logic [8:0]  COV_FULL          = 9'd256;
    localparam logic [16:0] ALPHA_ROUND       = 17'd128;

endpackage

`default_nettype wire

// ===== sv/rcam_if.sv =====
// Stream interfaces for the rounded-corner alpha mask: the pixel input
// channel and the result channel.
`default_nettype none

interface rcam_pix_if #(
    parameter int DIM_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] pix_x;
    logic [DIM_BITS-1:0] pix_y;
    logic [31:0]         pixel_in;

    modport source (output valid, output pix_x, output pix_y, output pixel_in, input ready);
    modport sink   (input valid, input pix_x, input pix_y, input pixel_in, output ready);
endinterface

interface rcam_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic [1:0]  corner_class;

    modport source (output valid, output pixel_out, output corner_class, input ready);
    modport sink   (input valid, input pixel_out, input corner_class, output ready);
endinterface

`default_nettype wire

// ===== sv/rcam_regs.sv =====
// APB configuration registers: frame width, frame height, corner radius.
// Depends on rcam_pkg for register indexes and reset values.
`default_nettype none

module rcam_regs
    import rcam_pkg::*;
#(
    parameter int DIM_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [DIM_BITS:0]     o_frame_width,
    output logic      [DIM_BITS:0]     o_frame_height,
    output logic      [DIM_BITS-1:0]   o_arc_radius
);

    logic [DIM_BITS:0]   r_frame_width;
    logic [DIM_BITS:0]   r_frame_height;
    logic [DIM_BITS-1:0] r_arc_radius;
    logic [1:0]          reg_index;
    logic                wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= (DIM_BITS+1)'(FRAME_SIZE_RESET);
            r_frame_height <= (DIM_BITS+1)'(FRAME_SIZE_RESET);
            r_arc_radius   <= DIM_BITS'(RADIUS_RESET);
        end else if (wr_en) begin
            unique case (reg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_BITS:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_BITS:0];
                REG_ARC_RADIUS:   r_arc_radius   <= pwdata[DIM_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read mux.
    always_comb begin
        unique case (reg_index)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            REG_ARC_RADIUS:   prdata = APB_DATA_W'(r_arc_radius);
            default:          prdata = '0;
        endcase
    end

    assign o_frame_width  = r_frame_width;
    assign o_frame_height = r_frame_height;
    assign o_arc_radius   = r_arc_radius;

endmodule

`default_nettype wire

// ===== sv/rcam_geom.sv =====
// Geometry front end: radius clamp, corner test, doubled distances,
// squares and the inner/outer classification, in four pipeline stages.
// Depends on rcam_pkg for the pixel word and class codes.
`default_nettype none

module rcam_geom
    import rcam_pkg::*;
#(
    parameter int DIM_BITS = 12
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [DIM_BITS:0]       i_frame_width,
    input  wire logic [DIM_BITS:0]       i_frame_height,
    input  wire logic [DIM_BITS-1:0]     i_arc_radius,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [DIM_BITS-1:0]     i_pix_x,
    input  wire logic [DIM_BITS-1:0]     i_pix_y,
    input  wire logic [31:0]             i_pixel,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output t_word                        o_word,
    output logic      [2*DIM_BITS+1:0]   o_rad,
    output logic      [DIM_BITS:0]       o_two_r_p1
);

    localparam int D    = DIM_BITS;
    localparam int SQ_W = 2 * DIM_BITS + 2;

    // Stage enables: a stage moves when it is empty or its successor moves.
    logic en1, en2, en3, en4;

    // Stage 1: clamped radius and frame test.
    logic          r_s1_valid;
    logic [D-1:0]  r_s1_x, r_s1_y, r_s1_r;
    logic          r_s1_bypass;
    logic [31:0]   r_s1_pix;

    // Stage 2: doubled distances.
    logic          r_s2_valid;
    logic [D:0]    r_s2_dx, r_s2_dy;
    logic [D-1:0]  r_s2_r;
    logic          r_s2_bypass;
    logic [31:0]   r_s2_pix;

    // Stage 3: squares.
    logic             r_s3_valid;
    logic [SQ_W-1:0]  r_s3_dx2, r_s3_dy2, r_s3_inner, r_s3_outer;
    logic [D:0]       r_s3_tp;
    logic             r_s3_bypass;
    logic [31:0]      r_s3_pix;

    // Stage 4: classification.
    logic             r_s4_valid;
    t_word            r_s4_word;
    logic [SQ_W-1:0]  r_s4_rad;
    logic [D:0]       r_s4_tp;

    assign en4     = !r_s4_valid || i_ready;
    assign en3     = !r_s3_valid || en4;
    assign en2     = !r_s2_valid || en3;
    assign en1     = !r_s1_valid || en2;
    assign o_ready = en1;

    // Stage 1 logic: clamp the radius to half the frame size.
    logic [D-1:0] half_w, half_h, r_clamp_w, r_eff;
    logic         outside;

    assign half_w    = i_frame_width[D:1];
    assign half_h    = i_frame_height[D:1];
    assign r_clamp_w = (i_arc_radius > half_w) ? half_w : i_arc_radius;
    assign r_eff     = (r_clamp_w > half_h) ? half_h : r_clamp_w;
    assign outside   = ({1'b0, i_pix_x} >= i_frame_width) ||
                       ({1'b0, i_pix_y} >= i_frame_height);

    // Stage 2 logic: distance from the nearer frame edge and DX, DY.
    logic [D:0]   x_sum, y_sum, x_tail, y_tail;
    logic         x_left, x_right, y_top, y_bottom;
    logic [D-1:0] ix, iy;
    logic         s2_bypass;

    assign x_sum    = {1'b0, r_s1_x} + {1'b0, r_s1_r};
    assign y_sum    = {1'b0, r_s1_y} + {1'b0, r_s1_r};
    assign x_left   = r_s1_x < r_s1_r;
    assign y_top    = r_s1_y < r_s1_r;
    assign x_right  = x_sum >= i_frame_width;
    assign y_bottom = y_sum >= i_frame_height;
    assign x_tail   = x_sum + (D+1)'(1) - i_frame_width;
    assign y_tail   = y_sum + (D+1)'(1) - i_frame_height;
    assign ix       = x_left ? (r_s1_r - r_s1_x) : x_tail[D-1:0];
    assign iy       = y_top  ? (r_s1_r - r_s1_y) : y_tail[D-1:0];
    assign s2_bypass = r_s1_bypass || (r_s1_r == '0) ||
                       !(x_left || x_right) || !(y_top || y_bottom);

    // Stage 4 logic: squared distance against inner and outer circles.
    logic [SQ_W:0] d2;

    assign d2 = {1'b0, r_s3_dx2} + {1'b0, r_s3_dy2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (en1) r_s1_valid <= i_valid;
            if (en2) r_s2_valid <= r_s1_valid;
            if (en3) r_s3_valid <= r_s2_valid;
            if (en4) r_s4_valid <= r_s3_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_x      <= i_pix_x;
            r_s1_y      <= i_pix_y;
            r_s1_r      <= r_eff;
            r_s1_bypass <= outside;
            r_s1_pix    <= i_pixel;
        end
        if (en2) begin
            r_s2_dx     <= {ix, 1'b0} - (D+1)'(1);
            r_s2_dy     <= {iy, 1'b0} - (D+1)'(1);
            r_s2_r      <= r_s1_r;
            r_s2_bypass <= s2_bypass;
            r_s2_pix    <= r_s1_pix;
        end
        if (en3) begin
            r_s3_dx2    <= SQ_W'(r_s2_dx) * SQ_W'(r_s2_dx);
            r_s3_dy2    <= SQ_W'(r_s2_dy) * SQ_W'(r_s2_dy);
            r_s3_inner  <= SQ_W'({r_s2_r, 1'b0} - (D+1)'(1)) *
                           SQ_W'({r_s2_r, 1'b0} - (D+1)'(1));
            r_s3_outer  <= SQ_W'({r_s2_r, 1'b1}) * SQ_W'({r_s2_r, 1'b1});
            r_s3_tp     <= {r_s2_r, 1'b1};
            r_s3_bypass <= r_s2_bypass;
            r_s3_pix    <= r_s2_pix;
        end
        if (en4) begin
            r_s4_rad <= d2[SQ_W-1:0];
            r_s4_tp  <= r_s3_tp;
            priority if (r_s3_bypass || (d2 <= {1'b0, r_s3_inner})) begin
                r_s4_word.cls   <= CLS_KEEP;
                r_s4_word.pixel <= r_s3_pix;
            end else if (d2 >= {1'b0, r_s3_outer}) begin
                r_s4_word.cls   <= CLS_CLEAR;
                r_s4_word.pixel <= PIXEL_CLEARED;
            end else begin
                r_s4_word.cls   <= CLS_SCALE;
                r_s4_word.pixel <= r_s3_pix;
            end
        end
    end

    assign o_valid    = r_s4_valid;
    assign o_word     = r_s4_word;
    assign o_rad      = r_s4_rad;
    assign o_two_r_p1 = r_s4_tp;

endmodule

`default_nettype wire

// ===== sv/rcam_sqrt_cell.sv =====
// One cell of the square-root row: takes two radicand bits, produces one
// root bit and hands the partial root, remainder and pixel word onward.
// Depends on rcam_pkg for the pixel word.
`default_nettype none

module rcam_sqrt_cell
    import rcam_pkg::*;
#(
    parameter int RAD_W  = 26,
    parameter int ROOT_W = 21,
    parameter int TP_W   = 13
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    output logic                     o_valid,
    input  wire logic                i_ready,
    input  wire t_word               i_word,
    output t_word                    o_word,
    input  wire logic [RAD_W-1:0]    i_rad,
    output logic      [RAD_W-1:0]    o_rad,
    input  wire logic [ROOT_W-1:0]   i_root,
    output logic      [ROOT_W-1:0]   o_root,
    input  wire logic [ROOT_W+1:0]   i_rem,
    output logic      [ROOT_W+1:0]   o_rem,
    input  wire logic [TP_W-1:0]     i_two_r_p1,
    output logic      [TP_W-1:0]     o_two_r_p1
);

    localparam int REM_W = ROOT_W + 2;

    logic              r_valid;
    t_word             r_word;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic [TP_W-1:0]   r_tp;
    logic              en;

    logic [REM_W-1:0]  rem_sh, trial;
    logic              take;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    // One restoring step: bring down two bits, try 4*root+1.
    assign rem_sh = {i_rem[REM_W-3:0], i_rad[RAD_W-1 -: 2]};
    assign trial  = {i_root, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_word <= i_word;
            r_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            r_root <= {i_root[ROOT_W-2:0], take};
            r_rem  <= take ? (rem_sh - trial) : rem_sh;
            r_tp   <= i_two_r_p1;
        end
    end

    assign o_valid    = r_valid;
    assign o_word     = r_word;
    assign o_rad      = r_rad;
    assign o_root     = r_root;
    assign o_rem      = r_rem;
    assign o_two_r_p1 = r_tp;

endmodule

`default_nettype wire

// ===== sv/rounded_corner_alpha_mask_top.sv =====
// Throughput: one pixel per cycle while the output is not stalled; the
// square-root row has one cell per root bit (DIM_BITS+9 cells) and each
// cell takes a new word every cycle unless stalled. Every stage holds its
// word while the next is full, so stalls back up. Reset is synchronous,
// active low: clears all valid bits and loads the registers with width
// 256, height 256, radius 0.
`default_nettype none

module rounded_corner_alpha_mask_top
    import rcam_pkg::*;
#(
    parameter int DIM_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    rcam_pix_if.sink                   i_pix,
    rcam_res_if.source                 o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int D      = DIM_BITS;
    localparam int SQ_W   = 2 * DIM_BITS + 2;
    localparam int ROOT_W = DIM_BITS + 9;
    localparam int REM_W  = ROOT_W + 2;
    localparam int NCELL  = ROOT_W;

    logic [D:0]   frame_width, frame_height;
    logic [D-1:0] arc_radius;

    // Configuration registers.
    rcam_regs #(.DIM_BITS(DIM_BITS)) u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_frame_width   (frame_width),
        .o_frame_height  (frame_height),
        .o_arc_radius    (arc_radius)
    );

    // Chain links between the front end, the cells and the back end.
    logic                w_valid [0:NCELL];
    logic                w_ready [0:NCELL];
    t_word               w_word  [0:NCELL];
    logic [SQ_W-1:0]     w_rad   [0:NCELL];
    logic [ROOT_W-1:0]   w_root  [0:NCELL];
    logic [REM_W-1:0]    w_rem   [0:NCELL];
    logic [D:0]          w_tp    [0:NCELL];

    // Geometry front end.
    rcam_geom #(.DIM_BITS(DIM_BITS)) u_geom (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_width   (frame_width),
        .i_frame_height  (frame_height),
        .i_arc_radius    (arc_radius),
        .i_valid         (i_pix.valid),
        .o_ready         (i_pix.ready),
        .i_pix_x         (i_pix.pix_x),
        .i_pix_y         (i_pix.pix_y),
        .i_pixel         (i_pix.pixel_in),
        .o_valid         (w_valid[0]),
        .i_ready         (w_ready[0]),
        .o_word          (w_word[0]),
        .o_rad           (w_rad[0]),
        .o_two_r_p1      (w_tp[0])
    );

    assign w_root[0] = '0;
    assign w_rem[0]  = '0;

    // Square-root row, one root bit per cell.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rcam_sqrt_cell #(
            .RAD_W  (SQ_W),
            .ROOT_W (ROOT_W),
            .TP_W   (D + 1)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_valid[k]),
            .o_ready    (w_ready[k]),
            .o_valid    (w_valid[k+1]),
            .i_ready    (w_ready[k+1]),
            .i_word     (w_word[k]),
            .o_word     (w_word[k+1]),
            .i_rad      (w_rad[k]),
            .o_rad      (w_rad[k+1]),
            .i_root     (w_root[k]),
            .o_root     (w_root[k+1]),
            .i_rem      (w_rem[k]),
            .o_rem      (w_rem[k+1]),
            .i_two_r_p1 (w_tp[k]),
            .o_two_r_p1 (w_tp[k+1])
        );
    end

    // Back end: coverage stage, then the output register.
    logic         r_c_valid;
    t_word        r_c_word;
    logic [8:0]   r_c_cov;
    logic         r_o_valid;
    t_word        r_o_word;
    logic         en_c, en_o;

    assign en_o           = !r_o_valid || o_res.ready;
    assign en_c           = !r_c_valid || en_o;
    assign w_ready[NCELL] = en_c;

    // Coverage: ((2r+1)*256 - root) / 2, clamped to 0..256.
    logic [ROOT_W-1:0] base;
    logic [ROOT_W:0]   diff;
    logic [ROOT_W-2:0] half;
    logic [8:0]        cov;

    assign base = {w_tp[NCELL], 8'h00};
    assign diff = {1'b0, base} - {1'b0, w_root[NCELL]};
    assign half = diff[ROOT_W-1:1];
    always_comb begin
        priority if (diff[ROOT_W]) begin
            cov = '0;
        end else if (half > (ROOT_W-1)'(COV_FULL)) begin
            cov = COV_FULL;
        end else begin
            cov = half[8:0];
        end
    end

    // Alpha scaling with rounding.
    logic [16:0] alpha_prod;
    logic [7:0]  new_alpha;

    assign alpha_prod = 17'(r_c_word.pixel[ALPHA_LSB +: 8]) * 17'(r_c_cov) + ALPHA_ROUND;
    assign new_alpha  = alpha_prod[15:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_c) r_c_valid <= w_valid[NCELL];
            if (en_o) r_o_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_word <= w_word[NCELL];
            r_c_cov  <= cov;
        end
        if (en_o) begin
            r_o_word.cls <= r_c_word.cls;
            if (r_c_word.cls == CLS_SCALE) begin
                r_o_word.pixel <= {new_alpha, r_c_word.pixel[ALPHA_LSB-1:0]};
            end else begin
                r_o_word.pixel <= r_c_word.pixel;
            end
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.pixel_out    = r_o_word.pixel;
    assign o_res.corner_class = r_o_word.cls;

`ifndef SYNTHESIS
    // A pixel in the soft band has a root between (2r-1)*256 and (2r+1)*256.
    a_band_root : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[NCELL] && (w_word[NCELL].cls == CLS_SCALE)) |->
            ((w_root[NCELL] < base) &&
             ({1'b0, w_root[NCELL]} + (ROOT_W+1)'(512) >= {1'b0, base})))
        else $error("square-root result outside the antialiasing band");

    // A cleared pixel leaves as all zeros.
    a_clear_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.corner_class == CLS_CLEAR)) |->
            (o_res.pixel_out == PIXEL_CLEARED))
        else $error("cleared pixel is not zero");

    // A word taken from the coverage stage reaches the output register.
    a_out_load : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && en_o) |=> r_o_valid)
        else $error("output register missed a word");
`endif

endmodule

`default_nettype wire

// ===== sim/rounded_corner_alpha_mask_top_tb.sv =====
// Self-checking testbench for rounded_corner_alpha_mask_top: streams pixels through
// the corner mask and checks each result word against a known or modelled word.
// Depends on rcam_pkg, the stream interfaces in rcam_if and the top level.
`default_nettype none

module rounded_corner_alpha_mask_top_tb;
    import rcam_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_BITS       = 12;
    localparam int RESULT_LATENCY = DIM_BITS + 15;
    localparam int STALL_LIMIT    = 2000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_WORDS    = 60;
    localparam int PROBE_COUNT    = 24;

    // Index just past the register list; writes there must have no effect.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // One directed probe: frame setup, pixel, and optionally a known result.
    typedef struct packed {
        logic [12:0]         width;
        logic [12:0]         height;
        logic [11:0]         radius;
        logic [DIM_BITS-1:0] col;
        logic [DIM_BITS-1:0] row;
        logic [31:0]         pixel;
        logic                known;
        logic [31:0]         known_pixel;
        t_cls                known_cls;
    } t_probe;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rcam_pix_if #(.DIM_BITS(DIM_BITS)) pix_bus ();
    rcam_res_if                        res_bus ();

    rounded_corner_alpha_mask_top #(.DIM_BITS(DIM_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the frame registers, as the mask model sees them.
    logic [12:0] frame_w;
    logic [12:0] frame_h;
    logic [11:0] radius;

    t_word masked_words [$];
    int        fault_count   = 0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;

    // Directed probes: extremes, every class, clamped radius, odd frames,
    // pixels outside the frame.
    t_probe probes [0:PROBE_COUNT-1] = '{
        '{256, 256, 0, 0, 0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, CLS_KEEP},
        '{256, 256, 0, 4095, 4095, 32'h0000_0000, 1'b1, 32'h0000_0000, CLS_KEEP},
        '{256, 256, 0, 17, 200, 32'h1234_5678, 1'b1, 32'h1234_5678, CLS_KEEP},
        '{4096, 4096, 2048, 0, 0, 32'hFFFF_FFFF, 1'b1, PIXEL_CLEARED, CLS_CLEAR},
        '{4096, 4096, 2048, 4095, 4095, 32'h80FF_00FF, 1'b1, PIXEL_CLEARED, CLS_CLEAR},
        '{4096, 4096, 2048, 4095, 0, 32'hC0DE_CAFE, 1'b1, PIXEL_CLEARED, CLS_CLEAR},
        '{4096, 4096, 2048, 2048, 2048, 32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF, CLS_KEEP},
        '{4096, 4096, 2048, 0, 2048, 32'hFF10_2030, 1'b0, 32'h0, CLS_KEEP},
        '{4096, 4096, 2048, 2047, 0, 32'h7F55_AA55, 1'b0, 32'h0, CLS_KEEP},
        '{1, 1, 4, 0, 0, 32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, CLS_KEEP},
        '{1, 1, 4, 1, 0, 32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A, CLS_KEEP},
        '{8, 8, 4, 0, 0, 32'hFFFF_FFFF, 1'b1, PIXEL_CLEARED, CLS_CLEAR},
        '{8, 8, 4, 7, 7, 32'h7F00_0000, 1'b1, PIXEL_CLEARED, CLS_CLEAR},
        '{8, 8, 4, 1, 0, 32'hFF00_FF00, 1'b0, 32'h0, CLS_KEEP},
        '{8, 8, 4, 0, 1, 32'h00FF_FFFF, 1'b0, 32'h0, CLS_KEEP},
        '{8, 8, 4, 6, 1, 32'h0100_0001, 1'b0, 32'h0, CLS_KEEP},
        '{8, 8, 4, 3, 4, 32'h1122_3344, 1'b1, 32'h1122_3344, CLS_KEEP},
        '{8, 8, 4, 8, 0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, CLS_KEEP},
        '{8, 8, 4, 0, 8, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, CLS_KEEP},
        '{3, 5, 2048, 0, 0, 32'hFFAB_CDEF, 1'b0, 32'h0, CLS_KEEP},
        '{3, 5, 2048, 1, 0, 32'hFFAB_CDEF, 1'b1, 32'hFFAB_CDEF, CLS_KEEP},
        '{3, 5, 2048, 2, 4, 32'h8000_0000, 1'b0, 32'h0, CLS_KEEP},
        '{4095, 4095, 2047, 0, 4094, 32'h3C3C_3C3C, 1'b0, 32'h0, CLS_KEEP},
        '{4095, 4095, 2047, 2047, 2047, 32'hC3C3_C3C3, 1'b0, 32'h0, CLS_KEEP}
    };

    // Free-running clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Floor square root, one result bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned value);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= value) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Expected result word for one pixel under the current frame setup.
    function automatic t_word mask_pixel(input logic [DIM_BITS-1:0] col,
                                         input logic [DIM_BITS-1:0] row,
                                         input logic [31:0] pixel);
        longint unsigned w, h, r, di, dj, dx, dy, dist2, inner, outer, root;
        longint unsigned alpha, new_alpha;
        longint          cov;
        t_word           word;
        word.pixel = pixel;
        word.cls   = CLS_KEEP;
        w = frame_w;
        h = frame_h;
        r = radius;
        if (r > w / 2) begin
            r = w / 2;
        end
        if (r > h / 2) begin
            r = h / 2;
        end
        if (r == 0 || col >= w || row >= h) begin
            return word;
        end

        // Distance from the nearest vertical and horizontal frame edge.
        if (col < r) begin
            di = col;
        end else if (col >= w - r) begin
            di = w - 1 - col;
        end else begin
            return word;
        end
        if (row < r) begin
            dj = row;
        end else if (row >= h - r) begin
            dj = h - 1 - row;
        end else begin
            return word;
        end

        // Doubled offsets from the circle center keep everything integer.
        dx    = 2 * r - 1 - 2 * di;
        dy    = 2 * r - 1 - 2 * dj;
        dist2 = dx * dx + dy * dy;
        inner = (2 * r - 1) * (2 * r - 1);
        outer = (2 * r + 1) * (2 * r + 1);
        if (dist2 <= inner) begin
            return word;
        end
        if (dist2 >= outer) begin
            word.pixel = PIXEL_CLEARED;
            word.cls   = CLS_CLEAR;
            return word;
        end

        // Edge band: scale alpha by the 9-bit coverage.
        root = floor_root(dist2 << 16);
        cov  = (longint'((2 * r + 1) * 256) - longint'(root)) / 2;
        if (cov < 0) begin
            cov = 0;
        end
        if (cov > 256) begin
            cov = 256;
        end
        alpha     = pixel[31:24];
        new_alpha = (alpha * unsigned'(cov) + 128) >> 8;
        if (new_alpha > 255) begin
            new_alpha = 255;
        end
        word.pixel = {new_alpha[7:0], pixel[23:0]};
        word.cls   = CLS_SCALE;
        return word;
    endfunction

    // One register write: setup phase, then access phase until pready.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
    endtask

    // Loads a new frame setup; only called while no pixel is in flight.
    task automatic load_frame(input int w, input int h, input int r);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_ARC_RADIUS, r);
        write_reg(REG_UNUSED, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frame_w = w;
        frame_h = h;
        radius  = r;
    endtask

    task automatic wait_drained();
        while (masked_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Sends one pixel word, with random idle cycles ahead of it.
    task automatic send_pixel(input logic [DIM_BITS-1:0] col,
                              input logic [DIM_BITS-1:0] row,
                              input logic [31:0] pixel, input t_word want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid    <= 1'b1;
        pix_bus.pix_x    <= col;
        pix_bus.pix_y    <= row;
        pix_bus.pixel_in <= pixel;
        do @(posedge i_clk); while (pix_bus.ready !== 1'b1);
        masked_words.push_back(want);
    endtask

    // Result side: random stalls, and each accepted word checked in order.
    initial begin
        t_word want;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
                if (masked_words.size() == 0) begin
                    $display("%0t: result word %h class %0d with nothing expected",
                             $time, res_bus.pixel_out, res_bus.corner_class);
                    fault_count++;
                end else begin
                    want = masked_words.pop_front();
                    if (res_bus.pixel_out !== want.pixel ||
                        res_bus.corner_class !== want.cls) begin
                        $display("%0t: expected pixel %h class %0d, got pixel %h class %0d",
                                 $time, want.pixel, want.cls,
                                 res_bus.pixel_out, res_bus.corner_class);
                        fault_count++;
                    end
                end
            end
            res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: ends the run once nothing has moved for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1) ||
                (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence: reset, directed probes, then randomized phases.
    initial begin
        int                  w, h, r, reff, roll, offset;
        logic [DIM_BITS-1:0] col, row;
        logic [31:0]         pixel;
        t_word               want;

        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        pix_bus.valid    <= 1'b0;
        pix_bus.pix_x    <= '0;
        pix_bus.pix_y    <= '0;
        pix_bus.pixel_in <= '0;
        frame_w = FRAME_SIZE_RESET;
        frame_h = FRAME_SIZE_RESET;
        radius  = RADIUS_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed probes; the frame is reloaded whenever a probe changes it.
        for (int k = 0; k < PROBE_COUNT; k++) begin
            if (probes[k].width != frame_w || probes[k].height != frame_h ||
                probes[k].radius != radius) begin
                pix_bus.valid <= 1'b0;
                wait_drained();
                load_frame(probes[k].width, probes[k].height, probes[k].radius);
            end
            if (probes[k].known) begin
                want.pixel = probes[k].known_pixel;
                want.cls   = probes[k].known_cls;
            end else begin
                want = mask_pixel(probes[k].col, probes[k].row, probes[k].pixel);
            end
            send_pixel(probes[k].col, probes[k].row, probes[k].pixel, want);
        end

        // Random phases, each loading a frame setup and an idle and stall pattern.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            pix_bus.valid <= 1'b0;
            wait_drained();
            if (ph == 0) begin
                w = 4096;
                h = 4096;
                r = 2048;
            end else if (ph == 1) begin
                w = 1;
                h = 1;
                r = 0;
            end else begin
                w = (ph == 3 || ph == 6) ? $urandom_range(1, 4096) : $urandom_range(1, 48);
                h = (ph == 3 || ph == 6) ? $urandom_range(1, 4096) : $urandom_range(1, 48);
                r = $urandom_range(0, ((w > h) ? w : h) / 2 + 2);
            end
            load_frame(w, h, r);
            send_idle_pct = (ph % 4 == 1) ? 47 : (ph % 4 == 3) ? 29 : 0;
            stall_pct     = (ph % 4 == 2) ? 47 : (ph % 4 == 3) ? 29 : 0;

            reff = r;
            if (reff > w / 2) begin
                reff = w / 2;
            end
            if (reff > h / 2) begin
                reff = h / 2;
            end

            for (int n = 0; n < PHASE_WORDS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 60 && reff > 0) begin
                    // Inside one of the four corner squares.
                    offset = $urandom_range(0, reff - 1);
                    col    = $urandom_range(0, 1) ? offset : w - 1 - offset;
                    offset = $urandom_range(0, reff - 1);
                    row    = $urandom_range(0, 1) ? offset : h - 1 - offset;
                end else if (roll < 85) begin
                    col = $urandom_range(0, w - 1);
                    row = $urandom_range(0, h - 1);
                end else begin
                    // Anywhere, mostly outside the frame for small frames.
                    col = $urandom_range(0, 4095);
                    row = $urandom_range(0, 4095);
                end
                pixel = $urandom;
                roll  = $urandom_range(0, 99);
                if (roll < 15) begin
                    pixel[31:24] = 8'hFF;
                end else if (roll < 25) begin
                    pixel[31:24] = 8'h00;
                end
                want = mask_pixel(col, row, pixel);
                send_pixel(col, row, pixel, want);
            end
        end

        // Let the pipeline empty, then watch a little longer for strays.
        pix_bus.valid <= 1'b0;
        wait_drained();
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);
        if (fault_count == 0 && masked_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
